// File: hdl/ssgt_pkg.sv
`default_nettype none
package ssgt_pkg;

    typedef struct packed {
        logic [7:0]         sensor_index;
        logic [31:0]        report_time;
        logic signed [31:0] sample_value;
        logic               line_malformed;
    } ssgt_in_t;

    typedef struct packed {
        logic [7:0]         out_sensor_index;
        logic [31:0]        report_count;
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
        logic signed [63:0] value_sum;
        logic signed [31:0] mean_value;
        logic [31:0]        gap_count;
        logic [31:0]        malformed_count;
        logic               was_malformed;
    } ssgt_out_t;

    // one table entry, stored as a single memory word
    typedef struct packed {
        logic [31:0]        count;
        logic signed [31:0] min_v;
        logic signed [31:0] max_v;
        logic signed [63:0] sum;
        logic [31:0]        last_time;
        logic [31:0]        gaps;
    } ssgt_rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIVIDE,
        ST_OUT
    } ssgt_state_t;

    localparam logic [31:0] GAP_THRESHOLD_RESET = 32'd500;
    localparam int          DIV_STEPS           = 64;

endpackage
`default_nettype wire

// File: hdl/sensor_stats_gap_tracker.sv
`default_nettype none
// Channel   Direction  Handshake       Payload
// in        input      in_valid/stall  ssgt_in_t
// out       output     out_valid/stall ssgt_out_t
// cfg       input      cfg_we          gap_threshold (32 bits)
//
// A valid report is offered as a result after the memory read, the update, a
// 64-step restoring divider for the mean (one quotient bit a cycle) and the
// result load; a malformed report is offered straight after the memory read.
// The next item is taken in the cycle after the result leaves.
// Reset (rst_n, async) clears the seen marks and the malformed total and
// sets the threshold to 500; the record memory itself is not cleared.
// A stalled result holds in the output register; in_stall stays high.
module sensor_stats_gap_tracker
    import ssgt_pkg::*;
#(
    parameter int NUM_SENSORS = 256
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output      logic      in_stall,
    input  wire ssgt_in_t  in_item,
    output      logic      out_valid,
    input  wire logic      out_stall,
    output      ssgt_out_t out_item,
    input  wire logic      cfg_we,
    input  wire logic [31:0] cfg_data
);

    localparam int AW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

    ssgt_state_t state_reg, state_next;
    logic [31:0]   thr_reg;
    logic [31:0]   mal_reg;
    logic [NUM_SENSORS-1:0] seen_reg;
    ssgt_in_t      item_reg;
    logic          bad_reg;
    ssgt_rec_t     rec_mem [NUM_SENSORS];
    ssgt_rec_t     rd_reg;
    ssgt_rec_t     upd_reg;
    ssgt_out_t     out_reg;
    logic [63:0]   rem_reg, quo_reg;
    logic          neg_reg;
    logic [6:0]    step_reg;
    logic [AW-1:0] addr;
    logic          accept;
    logic          in_bad;
    logic          fresh;
    ssgt_rec_t     base, upd;
    logic signed [64:0] sum_wide;
    logic signed [32:0] diff;
    logic [64:0]   trial;
    logic signed [31:0] mean;
    ssgt_out_t     res_ok, res_bad;

    assign accept   = in_valid && !in_stall;
    assign in_bad   = in_item.line_malformed ||
                      ({9'd0, in_item.sensor_index} >= 17'(NUM_SENSORS));
    assign addr     = AW'(item_reg.sensor_index);
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_item = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_READ;
            ST_READ:   state_next = bad_reg ? ST_OUT : ST_UPDATE;
            ST_UPDATE: state_next = ST_DIVIDE;
            ST_DIVIDE: if (step_reg == 7'(DIV_STEPS)) state_next = ST_OUT;
            ST_OUT:    if (!out_stall) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // merge first-report defaults and update the record
    always_comb
    begin
        fresh = !seen_reg[addr];
        base  = rd_reg;
        if (fresh)
        begin
            base.count     = '0;
            base.min_v     = item_reg.sample_value;
            base.max_v     = item_reg.sample_value;
            base.sum       = '0;
            base.last_time = item_reg.report_time;
            base.gaps      = '0;
        end
        upd = base;
        upd.count = (&base.count) ? base.count : base.count + 32'd1;
        if (item_reg.sample_value < base.min_v) upd.min_v = item_reg.sample_value;
        if (item_reg.sample_value > base.max_v) upd.max_v = item_reg.sample_value;
        sum_wide = {base.sum[63], base.sum} +
                   {{33{item_reg.sample_value[31]}}, item_reg.sample_value};
        if (sum_wide[64] != sum_wide[63])
            upd.sum = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            upd.sum = sum_wide[63:0];
        diff = $signed({1'b0, item_reg.report_time}) - $signed({1'b0, base.last_time});
        if (diff > $signed({1'b0, thr_reg}) && !(&base.gaps))
            upd.gaps = base.gaps + 32'd1;
        upd.last_time = item_reg.report_time;
    end

    // divider step, quotient saturation and result words
    always_comb
    begin
        trial = {rem_reg, quo_reg[63]} - {33'd0, upd_reg.count};
        if (upd_reg.count == 32'd0)
            mean = '0;
        else if (neg_reg)
            mean = (quo_reg > 64'h8000_0000) ? 32'sh8000_0000 : -quo_reg[31:0];
        else
            mean = (quo_reg > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : quo_reg[31:0];

        res_bad                 = '0;
        res_bad.malformed_count = mal_reg;
        res_bad.was_malformed   = 1'b1;

        res_ok.out_sensor_index = item_reg.sensor_index;
        res_ok.report_count     = upd_reg.count;
        res_ok.min_value        = upd_reg.min_v;
        res_ok.max_value        = upd_reg.max_v;
        res_ok.value_sum        = upd_reg.sum;
        res_ok.mean_value       = mean;
        res_ok.gap_count        = upd_reg.gaps;
        res_ok.malformed_count  = mal_reg;
        res_ok.was_malformed    = 1'b0;
    end

    // record memory: synchronous read, write back after update
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
            rd_reg <= rec_mem[AW'(in_item.sensor_index)];
        if (state_reg == ST_UPDATE)
            rec_mem[addr] <= upd_reg;
    end

    // payload path
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_item;
        if (state_reg == ST_READ)
        begin
            upd_reg <= upd;
            if (bad_reg)
                out_reg <= res_bad;
        end
        if (state_reg == ST_UPDATE)
        begin
            neg_reg  <= upd_reg.sum[63];
            quo_reg  <= upd_reg.sum[63] ? 64'd0 - upd_reg.sum : upd_reg.sum;
            rem_reg  <= '0;
            step_reg <= '0;
        end
        if (state_reg == ST_DIVIDE && step_reg != 7'(DIV_STEPS))
        begin
            step_reg <= step_reg + 7'd1;
            if (!trial[64])
            begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[62:0], quo_reg[63]};
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
        if (state_reg == ST_DIVIDE && step_reg == 7'(DIV_STEPS))
            out_reg <= res_ok;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            thr_reg   <= GAP_THRESHOLD_RESET;
            mal_reg   <= '0;
            seen_reg  <= '0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                thr_reg <= cfg_data;
            if (accept)
            begin
                bad_reg <= in_bad;
                if (in_bad && !(&mal_reg))
                    mal_reg <= mal_reg + 32'd1;
            end
            if (state_reg == ST_UPDATE)
                seen_reg[addr] <= 1'b1;
        end
    end

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> in_stall)
        else $error("input taken while result pending");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (step_reg <= 7'(DIV_STEPS)))
        else $error("divider overran");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_reg)))
        else $error("stalled result changed");

endmodule
`default_nettype wire
